>>> sv/asf_pkg.sv
// asf_pkg: shared types, constants and colour functions for the SGR stream filter.
// No dependencies; used by the top, asf_ctrl, asf_dp and the test bench files.
`default_nettype none
package asf_pkg;

    localparam logic [7:0] C_ESC      = 8'h1B;
    localparam logic [7:0] C_LBRACKET = 8'h5B;
    localparam logic [7:0] C_SEMI     = 8'h3B;
    localparam logic [7:0] C_DIGIT_0  = 8'h30;
    localparam logic [7:0] C_DIGIT_9  = 8'h39;
    localparam logic [7:0] C_FINAL_LO = 8'h40;
    localparam logic [7:0] C_FINAL_HI = 8'h7E;
    localparam logic [7:0] C_SGR_M    = 8'h6D;
    localparam logic [7:0] C_GREY_BASE = 8'd232;

    typedef enum logic [1:0] {
        ST_TEXT = 2'd0,
        ST_ESC  = 2'd1,
        ST_CSI  = 2'd2,
        ST_SGR  = 2'd3
    } t_state;

    typedef enum logic [1:0] {
        KIND_DEF = 2'd0,
        KIND_IDX = 2'd1,
        KIND_RGB = 2'd2
    } t_kind;

    // progress through an extended colour (38/48) during the SGR walk
    typedef enum logic [2:0] {
        X_NONE = 3'd0,
        X_MODE = 3'd1,
        X_IDX  = 3'd2,
        X_R    = 3'd3,
        X_G    = 3'd4,
        X_B    = 3'd5
    } t_ext;

    typedef struct packed {
        logic clear_col;
        logic emit;
        logic csi_start;
        logic digit;
        logic semi;
        logic push_final;
        logic reset_parse;
        logic sgr_start;
        logic sgr_step;
    } t_cmd;

    typedef struct packed {
        logic is_esc;
        logic is_lbracket;
        logic is_final;
        logic is_m;
        logic is_digit;
        logic is_semi;
        logic walk_done;
        logic out_full;
    } t_stat;

    function automatic logic [23:0] pal_rgb(input logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:  c = 24'h000000;
            4'd1:  c = 24'hCD3131;
            4'd2:  c = 24'h0DBC79;
            4'd3:  c = 24'hE5E510;
            4'd4:  c = 24'h2472C8;
            4'd5:  c = 24'hBC3FBC;
            4'd6:  c = 24'h11A8CD;
            4'd7:  c = 24'hE5E5E5;
            4'd8:  c = 24'h666666;
            4'd9:  c = 24'hF14C4C;
            4'd10: c = 24'h23D18B;
            4'd11: c = 24'hF5F543;
            4'd12: c = 24'h3B8EEA;
            4'd13: c = 24'hD670D6;
            4'd14: c = 24'h29B8DB;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cube_level(input logic [2:0] i);
        logic [7:0] lv;
        lv = (i == 3'd0) ? 8'd0 : 8'(8'(i) * 8'd40 + 8'd55);
        return lv;
    endfunction

    // 256-colour index to rgb; cube digits found by compare and subtract
    function automatic logic [23:0] from256(input logic [7:0] n);
        logic [7:0]  q;
        logic [2:0]  hi;
        logic [2:0]  mid;
        logic [5:0]  rem;
        logic [2:0]  lo;
        logic [7:0]  g;
        logic [23:0] c;
        hi  = 3'd0;
        mid = 3'd0;
        q   = n - 8'd16;
        for (int k = 1; k < 6; k++) begin
            if (q >= 8'(36 * k)) hi = 3'(k);
        end
        rem = 6'(q - 8'(8'(hi) * 8'd36));
        for (int k = 1; k < 6; k++) begin
            if (rem >= 6'(6 * k)) mid = 3'(k);
        end
        lo = 3'(rem - 6'(6'(mid) * 6'd6));
        g  = 8'(8'(n - C_GREY_BASE) * 8'd10 + 8'd8);
        if (n < 8'd16) begin
            c = pal_rgb(n[3:0]);
        end else if (n < C_GREY_BASE) begin
            c = {cube_level(hi), cube_level(mid), cube_level(lo)};
        end else begin
            c = {g, g, g};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> sv/asf_if.sv
// asf_in_if / asf_out_if: valid-ready channels of the SGR stream filter.
// Depends on nothing.
`default_nettype none
interface asf_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;
    logic       end_of_chunk;
    modport source (output valid, action, in_byte, end_of_chunk, input ready);
    modport sink   (input valid, action, in_byte, end_of_chunk, output ready);
endinterface

interface asf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        fg_is_default;
    logic [23:0] fg_rgb;
    logic        bg_is_default;
    logic [23:0] bg_rgb;
    logic        bold_on;
    modport source (output valid, out_byte, fg_is_default, fg_rgb, bg_is_default, bg_rgb,
                    bold_on, input ready);
    modport sink   (input valid, out_byte, fg_is_default, fg_rgb, bg_is_default, bg_rgb,
                    bold_on, output ready);
endinterface
`default_nettype wire

>>> sv/ansi_sgr_stream_filter_top.sv
// A visible byte appears on the output, registered, in the cycle after its transfer.
// Text and sequence bytes are taken one byte per cycle while the output does not stall; after a
// final 'm', input is held off while the datapath walks the stored parameters one per cycle.
// Reset: synchronous active-low; parser returns to text mode, colours to default,
// output empties. Parameter store is not cleared.
// ansi_sgr_stream_filter_top: joins asf_ctrl and asf_dp; uses asf_pkg and asf_if.
`default_nettype none
module ansi_sgr_stream_filter_top #(
    parameter int MAX_PARAMS = 16
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    asf_in_if.sink   i_in,
    asf_out_if.source o_out
);
    asf_pkg::t_cmd  w_cmd;
    asf_pkg::t_stat w_stat;

    asf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_action (i_in.action),
        .i_last   (i_in.end_of_chunk),
        .i_stat   (w_stat),
        .o_ready  (i_in.ready),
        .o_cmd    (w_cmd)
    );

    asf_dp #(.MAX_PARAMS(MAX_PARAMS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte          (i_in.in_byte),
        .i_cmd           (w_cmd),
        .i_out_ready     (o_out.ready),
        .o_stat          (w_stat),
        .o_valid         (o_out.valid),
        .o_out_byte      (o_out.out_byte),
        .o_fg_is_default (o_out.fg_is_default),
        .o_fg_rgb        (o_out.fg_rgb),
        .o_bg_is_default (o_out.bg_is_default),
        .o_bg_rgb        (o_out.bg_rgb),
        .o_bold_on       (o_out.bold_on)
    );
endmodule
`default_nettype wire

>>> sv/asf_ctrl.sv
// asf_ctrl: parser state machine; issues commands to the datapath.
// Depends on asf_pkg.
`default_nettype none
module asf_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire                  i_action,
    input  wire                  i_last,
    input  wire asf_pkg::t_stat  i_stat,
    output logic                 o_ready,
    output asf_pkg::t_cmd        o_cmd
);
    asf_pkg::t_state r_state, n_state;
    logic            w_accept;

    assign o_ready  = (r_state != asf_pkg::ST_SGR) && !i_stat.out_full;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asf_pkg::ST_TEXT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        if (r_state == asf_pkg::ST_SGR) begin
            if (i_stat.walk_done) n_state = asf_pkg::ST_TEXT;
        end else if (w_accept && !i_action) begin
            unique case (r_state)
                asf_pkg::ST_TEXT: begin
                    if (i_stat.is_esc) n_state = asf_pkg::ST_ESC;
                end
                asf_pkg::ST_ESC: begin
                    n_state = i_stat.is_lbracket ? asf_pkg::ST_CSI : asf_pkg::ST_TEXT;
                end
                asf_pkg::ST_CSI: begin
                    if (i_stat.is_final) begin
                        n_state = i_stat.is_m ? asf_pkg::ST_SGR : asf_pkg::ST_TEXT;
                    end
                end
                default: n_state = r_state;
            endcase
            // end of chunk drops an unfinished sequence
            if (i_last && n_state != asf_pkg::ST_TEXT && n_state != asf_pkg::ST_SGR) begin
                n_state = asf_pkg::ST_TEXT;
            end
        end
    end

    always_comb begin
        o_cmd = '0;
        if (r_state == asf_pkg::ST_SGR) begin
            o_cmd.sgr_step = 1'b1;
        end else if (w_accept) begin
            if (i_action) begin
                o_cmd.clear_col = 1'b1;
            end else begin
                unique case (r_state)
                    asf_pkg::ST_TEXT: o_cmd.emit = !i_stat.is_esc;
                    asf_pkg::ST_ESC:  o_cmd.csi_start = i_stat.is_lbracket;
                    asf_pkg::ST_CSI: begin
                        o_cmd.push_final = i_stat.is_final;
                        o_cmd.sgr_start  = i_stat.is_final && i_stat.is_m;
                        o_cmd.digit      = i_stat.is_digit;
                        o_cmd.semi       = i_stat.is_semi;
                    end
                    default: o_cmd = '0;
                endcase
                o_cmd.reset_parse = i_last && (n_state == asf_pkg::ST_TEXT)
                                    && (r_state != asf_pkg::ST_TEXT)
                                    && !(r_state == asf_pkg::ST_CSI && i_stat.is_final);
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/asf_dp.sv
// asf_dp: parameter store, accumulator, SGR walk, colour state and output register.
// Depends on asf_pkg.
`default_nettype none
module asf_dp #(
    parameter int MAX_PARAMS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire [7:0]            i_byte,
    input  wire asf_pkg::t_cmd   i_cmd,
    input  wire                  i_out_ready,
    output asf_pkg::t_stat       o_stat,
    output logic                 o_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_fg_is_default,
    output logic [23:0]          o_fg_rgb,
    output logic                 o_bg_is_default,
    output logic [23:0]          o_bg_rgb,
    output logic                 o_bold_on
);
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam int IW = $clog2(MAX_PARAMS);
    localparam logic [CW-1:0] MAXC = CW'(MAX_PARAMS);

    logic [15:0]       r_store [MAX_PARAMS];
    logic [CW-1:0]     r_count;
    logic [15:0]       r_acc;
    logic              r_digit;
    logic [CW-1:0]     r_idx;
    asf_pkg::t_ext     r_ext;
    logic              r_ext_fg;
    logic [7:0]        r_red, r_grn;
    asf_pkg::t_kind    r_fg_kind, r_bg_kind;
    logic [23:0]       r_fg_val, r_bg_val;
    logic              r_bold;
    logic              r_valid;
    logic [7:0]        r_ob;
    logic              r_ofd, r_obd, r_obold;
    logic [23:0]       r_ofg, r_obg;

    logic [15:0]       w_v;
    logic              w_push;
    logic [CW+1:0]     w_idx_ext;
    logic [3:0]        w_fidx;
    logic [23:0]       w_fg, w_bg;
    logic [15:0]       w_acc_next;

    assign o_stat.is_esc      = (i_byte == asf_pkg::C_ESC);
    assign o_stat.is_lbracket = (i_byte == asf_pkg::C_LBRACKET);
    assign o_stat.is_final    = (i_byte >= asf_pkg::C_FINAL_LO)
                                && (i_byte <= asf_pkg::C_FINAL_HI);
    assign o_stat.is_m        = (i_byte == asf_pkg::C_SGR_M);
    assign o_stat.is_digit    = (i_byte >= asf_pkg::C_DIGIT_0)
                                && (i_byte <= asf_pkg::C_DIGIT_9);
    assign o_stat.is_semi     = (i_byte == asf_pkg::C_SEMI);
    assign o_stat.walk_done   = (r_count == '0) || (r_idx + 1'b1 >= r_count);
    assign o_stat.out_full    = r_valid && !i_out_ready;

    assign w_v        = r_store[r_idx[IW-1:0]];
    assign w_push     = (r_count < MAXC)
                        && (i_cmd.semi || (i_cmd.push_final && (r_digit || r_count != '0)));
    assign w_idx_ext  = (CW+2)'(r_idx) + (CW+2)'(3);
    assign w_acc_next = 16'(r_acc * 16'd10 + 16'(i_byte - asf_pkg::C_DIGIT_0));

    always_ff @(posedge i_clk) begin
        if (w_push) r_store[r_count[IW-1:0]] <= r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_acc   <= '0;
            r_digit <= 1'b0;
        end else if (i_cmd.csi_start || i_cmd.reset_parse) begin
            r_count <= '0;
            r_acc   <= '0;
            r_digit <= 1'b0;
        end else begin
            if (w_push) r_count <= r_count + 1'b1;
            if (i_cmd.digit) begin
                r_acc   <= w_acc_next;
                r_digit <= 1'b1;
            end else if (i_cmd.semi) begin
                r_acc   <= '0;
                r_digit <= 1'b0;
            end
        end
    end

    // SGR walk: one stored parameter per cycle; a clear action resets the colours
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_ext     <= asf_pkg::X_NONE;
            r_ext_fg  <= 1'b0;
            r_fg_kind <= asf_pkg::KIND_DEF;
            r_bg_kind <= asf_pkg::KIND_DEF;
            r_fg_val  <= '0;
            r_bg_val  <= '0;
            r_bold    <= 1'b0;
        end else if (i_cmd.clear_col) begin
            r_fg_kind <= asf_pkg::KIND_DEF;
            r_bg_kind <= asf_pkg::KIND_DEF;
            r_fg_val  <= '0;
            r_bg_val  <= '0;
            r_bold    <= 1'b0;
        end else if (i_cmd.sgr_start) begin
            r_idx <= '0;
            r_ext <= asf_pkg::X_NONE;
        end else if (i_cmd.sgr_step) begin
            r_idx <= r_idx + 1'b1;
            if (r_count == '0) begin
                r_fg_kind <= asf_pkg::KIND_DEF;
                r_bg_kind <= asf_pkg::KIND_DEF;
                r_fg_val  <= '0;
                r_bg_val  <= '0;
                r_bold    <= 1'b0;
            end else begin
                unique case (r_ext)
                    asf_pkg::X_MODE: begin
                        if (w_v == 16'd5) begin
                            r_ext <= asf_pkg::X_IDX;
                        end else if (w_v == 16'd2 && w_idx_ext < (CW+2)'(r_count)) begin
                            r_ext <= asf_pkg::X_R;
                        end else begin
                            r_ext <= asf_pkg::X_NONE;
                        end
                    end
                    asf_pkg::X_IDX: begin
                        r_ext <= asf_pkg::X_NONE;
                        if (r_ext_fg) begin
                            r_fg_kind <= asf_pkg::KIND_RGB;
                            r_fg_val  <= asf_pkg::from256(w_v[7:0]);
                        end else begin
                            r_bg_kind <= asf_pkg::KIND_RGB;
                            r_bg_val  <= asf_pkg::from256(w_v[7:0]);
                        end
                    end
                    asf_pkg::X_R: begin
                        r_red <= w_v[7:0];
                        r_ext <= asf_pkg::X_G;
                    end
                    asf_pkg::X_G: begin
                        r_grn <= w_v[7:0];
                        r_ext <= asf_pkg::X_B;
                    end
                    asf_pkg::X_B: begin
                        r_ext <= asf_pkg::X_NONE;
                        if (r_ext_fg) begin
                            r_fg_kind <= asf_pkg::KIND_RGB;
                            r_fg_val  <= {r_red, r_grn, w_v[7:0]};
                        end else begin
                            r_bg_kind <= asf_pkg::KIND_RGB;
                            r_bg_val  <= {r_red, r_grn, w_v[7:0]};
                        end
                    end
                    default: begin
                        if (w_v == 16'd0) begin
                            r_fg_kind <= asf_pkg::KIND_DEF;
                            r_bg_kind <= asf_pkg::KIND_DEF;
                            r_fg_val  <= '0;
                            r_bg_val  <= '0;
                            r_bold    <= 1'b0;
                        end else if (w_v == 16'd1) begin
                            r_bold <= 1'b1;
                        end else if (w_v == 16'd22) begin
                            r_bold <= 1'b0;
                        end else if (w_v >= 16'd30 && w_v <= 16'd37) begin
                            r_fg_kind <= asf_pkg::KIND_IDX;
                            r_fg_val  <= 24'(w_v - 16'd30);
                        end else if (w_v >= 16'd90 && w_v <= 16'd97) begin
                            r_fg_kind <= asf_pkg::KIND_IDX;
                            r_fg_val  <= 24'(w_v - 16'd82);
                        end else if (w_v == 16'd39) begin
                            r_fg_kind <= asf_pkg::KIND_DEF;
                            r_fg_val  <= '0;
                        end else if (w_v >= 16'd40 && w_v <= 16'd47) begin
                            r_bg_kind <= asf_pkg::KIND_IDX;
                            r_bg_val  <= 24'(w_v - 16'd40);
                        end else if (w_v >= 16'd100 && w_v <= 16'd107) begin
                            r_bg_kind <= asf_pkg::KIND_IDX;
                            r_bg_val  <= 24'(w_v - 16'd92);
                        end else if (w_v == 16'd49) begin
                            r_bg_kind <= asf_pkg::KIND_DEF;
                            r_bg_val  <= '0;
                        end else if (w_v == 16'd38 || w_v == 16'd48) begin
                            r_ext    <= asf_pkg::X_MODE;
                            r_ext_fg <= (w_v == 16'd38);
                        end
                    end
                endcase
            end
        end
    end

    // colour resolution for the emitted byte
    always_comb begin
        w_fidx = r_fg_val[3:0];
        if (r_bold && !w_fidx[3]) w_fidx = w_fidx + 4'd8;
        unique case (r_fg_kind)
            asf_pkg::KIND_IDX: w_fg = asf_pkg::pal_rgb(w_fidx);
            asf_pkg::KIND_RGB: w_fg = r_fg_val;
            default:           w_fg = '0;
        endcase
        unique case (r_bg_kind)
            asf_pkg::KIND_IDX: w_bg = asf_pkg::pal_rgb(r_bg_val[3:0]);
            asf_pkg::KIND_RGB: w_bg = r_bg_val;
            default:           w_bg = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ob    <= i_byte;
            r_ofd   <= (r_fg_kind == asf_pkg::KIND_DEF);
            r_ofg   <= w_fg;
            r_obd   <= (r_bg_kind == asf_pkg::KIND_DEF);
            r_obg   <= w_bg;
            r_obold <= r_bold;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_ob;
    assign o_fg_is_default = r_ofd;
    assign o_fg_rgb        = r_ofg;
    assign o_bg_is_default = r_obd;
    assign o_bg_rgb        = r_obg;
    assign o_bold_on       = r_obold;
endmodule
`default_nettype wire

>>> sv/asf_checker.sv
// asf_checker: port-level assertions for the SGR stream filter, bound to the top.
// Depends on the top level's ports only.
`default_nettype none
module asf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_in_action,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [7:0]  i_out_byte
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte))
        else $error("output byte changed while stalled");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("block not empty and ready after reset");

    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_action && (!i_out_valid || i_out_ready)
        |=> !i_out_valid)
        else $error("clear action produced a result");
endmodule

bind ansi_sgr_stream_filter_top asf_checker u_asf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte)
);
`default_nettype wire

>>> test/asf_checker.sv
// asf_scoreboard: watches both channels of the SGR stream filter, predicts each visible byte
// with its colours and compares. Depends on asf_pkg and asf_if.
`default_nettype none
module asf_scoreboard (
    input  wire        i_clk,
    input  wire        i_rst_n,
    asf_in_if.sink     i_in_mon,
    asf_out_if.sink    i_out_mon,
    output int         o_errors,
    output int         o_pending,
    output int         o_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  ch;
        logic        fg_def;
        logic [23:0] fg;
        logic        bg_def;
        logic [23:0] bg;
        logic        bold;
    } t_glyph;

    localparam int N_PARAMS = 16;

    t_glyph           glyph_q[$];
    asf_pkg::t_state  mode;
    logic [15:0]      params[N_PARAMS];
    int               n_params;
    logic [15:0]      accum;
    logic             got_digit;
    asf_pkg::t_kind   fg_kind, bg_kind;
    logic [23:0]      fg_val, bg_val;
    logic             bold;

    function automatic logic [23:0] palette(input logic [3:0] idx);
        logic [23:0] tab[16];
        tab = '{24'h000000, 24'hCD3131, 24'h0DBC79, 24'hE5E510, 24'h2472C8, 24'hBC3FBC,
                24'h11A8CD, 24'hE5E5E5, 24'h666666, 24'hF14C4C, 24'h23D18B, 24'hF5F543,
                24'h3B8EEA, 24'hD670D6, 24'h29B8DB, 24'hFFFFFF};
        return tab[idx];
    endfunction

    function automatic logic [7:0] level6(input int i);
        return (i == 0) ? 8'd0 : 8'(i * 40 + 55);
    endfunction

    function automatic logic [23:0] xterm_rgb(input int n);
        int q, g;
        if (n < 16) return palette(4'(n));
        if (n < 232) begin
            q = n - 16;
            return {level6(q / 36), level6((q / 6) % 6), level6(q % 6)};
        end
        g = (n - 232) * 10 + 8;
        return {8'(g), 8'(g), 8'(g)};
    endfunction

    task automatic reset_colours();
        fg_kind = asf_pkg::KIND_DEF; fg_val = '0;
        bg_kind = asf_pkg::KIND_DEF; bg_val = '0;
        bold = 1'b0;
    endtask

    task automatic paint(input logic is_fg, input asf_pkg::t_kind k, input logic [23:0] v);
        if (is_fg) begin
            fg_kind = k; fg_val = v;
        end else begin
            bg_kind = k; bg_val = v;
        end
    endtask

    task automatic apply_sgr();
        int v, i, md;
        logic is_fg;
        if (n_params == 0) begin
            reset_colours();
            return;
        end
        i = 0;
        while (i < n_params) begin
            v = params[i];
            if (v == 0) reset_colours();
            else if (v == 1) bold = 1'b1;
            else if (v == 22) bold = 1'b0;
            else if (v >= 30 && v <= 37) paint(1, asf_pkg::KIND_IDX, 24'(v - 30));
            else if (v >= 90 && v <= 97) paint(1, asf_pkg::KIND_IDX, 24'(v - 82));
            else if (v == 39) paint(1, asf_pkg::KIND_DEF, '0);
            else if (v >= 40 && v <= 47) paint(0, asf_pkg::KIND_IDX, 24'(v - 40));
            else if (v >= 100 && v <= 107) paint(0, asf_pkg::KIND_IDX, 24'(v - 92));
            else if (v == 49) paint(0, asf_pkg::KIND_DEF, '0);
            else if ((v == 38 || v == 48) && i + 1 < n_params) begin
                is_fg = (v == 38);
                i++;
                md = params[i];
                if (md == 5 && i + 1 < n_params) begin
                    i++;
                    paint(is_fg, asf_pkg::KIND_RGB, xterm_rgb(params[i] & 8'hFF));
                end else if (md == 2 && i + 3 < n_params) begin
                    paint(is_fg, asf_pkg::KIND_RGB, {params[i+1][7:0], params[i+2][7:0],
                                                     params[i+3][7:0]});
                    i += 3;
                end
            end
            i++;
        end
    endtask

    task automatic push_param();
        if (n_params < N_PARAMS) begin
            params[n_params] = accum;
            n_params++;
        end
    endtask

    task automatic predict(input logic act, input logic [7:0] b, input logic last);
        t_glyph gl;
        logic [3:0] idx;
        if (act) begin
            reset_colours();
            return;
        end
        case (mode)
            asf_pkg::ST_ESC: begin
                if (b == asf_pkg::C_LBRACKET) begin
                    mode = asf_pkg::ST_CSI; n_params = 0; accum = '0; got_digit = 0;
                end else mode = asf_pkg::ST_TEXT;
            end
            asf_pkg::ST_CSI: begin
                if (b >= asf_pkg::C_FINAL_LO && b <= asf_pkg::C_FINAL_HI) begin
                    if (got_digit || n_params > 0) push_param();
                    if (b == asf_pkg::C_SGR_M) apply_sgr();
                    mode = asf_pkg::ST_TEXT;
                end else if (b >= asf_pkg::C_DIGIT_0 && b <= asf_pkg::C_DIGIT_9) begin
                    accum = 16'(accum * 10 + (b - asf_pkg::C_DIGIT_0));
                    got_digit = 1;
                end else if (b == asf_pkg::C_SEMI) begin
                    push_param(); accum = '0; got_digit = 0;
                end
            end
            default: begin
                if (b == asf_pkg::C_ESC) mode = asf_pkg::ST_ESC;
                else begin
                    gl.ch = b;
                    gl.fg_def = (fg_kind == asf_pkg::KIND_DEF);
                    gl.fg = '0;
                    if (fg_kind == asf_pkg::KIND_IDX) begin
                        idx = fg_val[3:0];
                        if (bold && idx <= 7) idx = idx + 8;
                        gl.fg = palette(idx);
                    end else if (fg_kind == asf_pkg::KIND_RGB) gl.fg = fg_val;
                    gl.bg_def = (bg_kind == asf_pkg::KIND_DEF);
                    gl.bg = (bg_kind == asf_pkg::KIND_IDX) ? palette(bg_val[3:0]) :
                            (bg_kind == asf_pkg::KIND_RGB) ? bg_val : 24'h0;
                    gl.bold = bold;
                    glyph_q.push_back(gl);
                end
            end
        endcase
        if (last && mode != asf_pkg::ST_TEXT) begin
            mode = asf_pkg::ST_TEXT; n_params = 0; accum = '0; got_digit = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_glyph want, got;
        if (!i_rst_n) begin
            mode = asf_pkg::ST_TEXT; n_params = 0; accum = '0; got_digit = 0;
            reset_colours();
            glyph_q.delete();
            o_errors <= 0;
            o_seen <= 0;
            o_pending <= 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = {i_out_mon.out_byte, i_out_mon.fg_is_default, i_out_mon.fg_rgb,
                       i_out_mon.bg_is_default, i_out_mon.bg_rgb, i_out_mon.bold_on};
                o_seen <= o_seen + 1;
                if (glyph_q.size() == 0) begin
                    $display("%0t: unexpected output transfer, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = glyph_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected byte %h fgd %b fg %h bgd %b bg %h bold %b",
                                 $time, want.ch, want.fg_def, want.fg, want.bg_def, want.bg,
                                 want.bold);
                        $display("%0t:          actual   byte %h fgd %b fg %h bgd %b bg %h bold %b",
                                 $time, got.ch, got.fg_def, got.fg, got.bg_def, got.bg, got.bold);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict(i_in_mon.action, i_in_mon.in_byte, i_in_mon.end_of_chunk);
            o_pending <= glyph_q.size();
        end
    end
endmodule
`default_nettype wire

>>> test/tb.sv
// tb: stimulus and verdict for ansi_sgr_stream_filter_top; checking lives in asf_scoreboard.
// Depends on asf_pkg, asf_if, the block and asf_scoreboard.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   errors, pending, seen;
    int   n_items = 0;
    bit   quiet = 0;

    asf_in_if  in_ch();
    asf_out_if out_ch();

    ansi_sgr_stream_filter_top dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch),
                                    .o_out(out_ch));
    asf_scoreboard chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_mon(in_ch),
                        .i_out_mon(out_ch), .o_errors(errors), .o_pending(pending),
                        .o_seen(seen));

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0; in_ch.action = 1'b0; in_ch.in_byte = '0;
        in_ch.end_of_chunk = 1'b0; out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls about 24% of cycles, never during the quiet stretch
    always @(posedge i_clk)
        out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);

    // one transfer; valid stays up across back-to-back items unless a random gap is inserted
    task automatic send(input logic act, input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(99) < 24) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.in_byte <= b;
        in_ch.end_of_chunk <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        n_items++;
    endtask

    task automatic send_str(input string s, input logic last_on_end);
        for (int k = 0; k < s.len(); k++)
            send(1'b0, s[k], last_on_end && k == s.len() - 1);
    endtask

    task automatic send_num(input int v);
        send_str($sformatf("%0d", v), 0);
    endtask

    // well-formed SGR with random codes, occasionally broken
    task automatic random_sgr();
        int np, kind;
        send(1'b0, asf_pkg::C_ESC, 0);
        send(1'b0, asf_pkg::C_LBRACKET, 0);
        np = $urandom_range(6);
        for (int k = 0; k < np; k++) begin
            kind = $urandom_range(9);
            case (kind)
                0: send_num($urandom_range(1));
                1: send_num(30 + $urandom_range(9));
                2: send_num(40 + $urandom_range(9));
                3: send_num(90 + $urandom_range(17));
                4: begin
                    send_num($urandom_range(1) ? 38 : 48); send(0, asf_pkg::C_SEMI, 0);
                    send_num(5); send(0, asf_pkg::C_SEMI, 0); send_num($urandom_range(300));
                end
                5: begin
                    send_num($urandom_range(1) ? 38 : 48); send(0, asf_pkg::C_SEMI, 0);
                    send_num(2);
                    for (int c = 0; c < 3; c++) begin
                        send(0, asf_pkg::C_SEMI, 0); send_num($urandom_range(65535));
                    end
                end
                6: send_num(22);
                7: send_num($urandom_range(65535));
                8: send(0, 8'($urandom_range(8'h20, 8'h2F)), 0);
                default: ;
            endcase
            if (k < np - 1) send(0, asf_pkg::C_SEMI, 0);
        end
        case ($urandom_range(9))
            0: send(0, 8'($urandom_range(asf_pkg::C_FINAL_LO, asf_pkg::C_FINAL_HI)), 0);
            1: send(0, 8'($urandom_range(255)), 1);
            default: send(0, asf_pkg::C_SGR_M, 0);
        endcase
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, NUL, colour forms, overflow, other finals, clear
        send(0, 8'h00, 0); send(0, 8'hFF, 1);
        send_str("\033[1;31mA", 0);
        send_str("\033[38;5;9mB\033[48;5;100mC", 0);
        send_str("\033[38;5;250;48;2;300;1;65535mD", 0);
        send_str("\033[mE\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;31mF", 0);
        send_str("\033[99999;38mG\033[5H\033[ !mH\033(xI", 0);
        send_str("\033[97;107;39;49;38;2;1mJ", 0);
        send(0, asf_pkg::C_ESC, 0); send(0, asf_pkg::C_LBRACKET, 1);
        send_str("\033[44mK", 0); send(1, 8'h1B, 1); send(0, 8'h4C, 0);
        wait_drain();

        while (n_items < 1100) begin
            quiet = (n_items >= 500 && n_items < 650);
            r = $urandom_range(99);
            if (r < 40) random_sgr();
            else if (r < 85) send(0, 8'($urandom_range(8'h20, 8'h7E)), $urandom_range(15) == 0);
            else if (r < 88) send(1, 8'($urandom), 1'($urandom));
            else if (r < 91) begin
                send(0, asf_pkg::C_ESC, 0); send(0, 8'($urandom), 1'($urandom));
            end else send(0, 8'($urandom), 1'($urandom));
            if (n_items > 800 && n_items < 830) wait_drain();
        end
        quiet = 0;
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);

        $display("sent %0d input transfers, checked %0d visible bytes", n_items, seen);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
